// ===== hdl/psd_pkg.sv =====
// ----------------------------------------------------------------------------
// psd_pkg
// shared widths and limits for the point to segment distance pipeline
// ----------------------------------------------------------------------------
package psd_pkg;
  localparam int DIST_BITS = 25;
  localparam int THR_BITS  = 25;
  localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};
endpackage

// ===== hdl/point_segment_distance.sv =====
// ----------------------------------------------------------------------------
// point_segment_distance
// floor of point to segment distance and threshold flag, fully pipelined
// ----------------------------------------------------------------------------
// an accepted input passes the front stages, cell chain and output register
// throughput: one transaction per cycle; a stalled output holds the whole pipe
// the root extraction is a chain of COORD_BITS + 2 cells, one result bit each
// reset (rst, synchronous) clears all valid bits and the threshold register
module point_segment_distance import psd_pkg::*; #(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [THR_BITS-1:0]          cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic signed [COORD_BITS-1:0] head_x,
  input  logic signed [COORD_BITS-1:0] head_y,
  input  logic signed [COORD_BITS-1:0] tail_x,
  input  logic signed [COORD_BITS-1:0] tail_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [DIST_BITS-1:0]         distance,
  output logic                         within_res
);
  localparam int W   = COORD_BITS + 1;
  localparam int NW  = 4 * W;        // squared numerator width
  localparam int DNW = 2 * W;        // denominator width
  localparam int DB  = COORD_BITS + 2;  // result bits before saturation
  localparam int QW  = DB + DNW;
  localparam int CW  = (DB > THR_BITS) ? DB : THR_BITS;

  logic [THR_BITS-1:0] threshold;
  logic                en;

  // whole pipe advances unless a finished result is held by the sink
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
    end else if (cfg_we) begin
      threshold <= cfg_wdata;
    end
  end

  logic            f_valid;
  logic [NW-1:0]   f_num;
  logic [DNW-1:0]  f_den;

  psd_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_ok   (in_valid),
    .px      (point_x),
    .py      (point_y),
    .hx      (head_x),
    .hy      (head_y),
    .tx      (tail_x),
    .ty      (tail_y),
    .f_valid (f_valid),
    .f_num   (f_num),
    .f_den   (f_den)
  );

  // chain of cells, most significant result bit first
  logic            c_valid [DB+1];
  logic [NW-1:0]   c_rem   [DB+1];
  logic [QW-1:0]   c_q     [DB+1];
  logic [DNW-1:0]  c_den   [DB+1];
  logic [DB-1:0]   c_d     [DB+1];

  assign c_valid[0] = f_valid;
  assign c_rem[0]   = f_num;
  assign c_q[0]     = '0;
  assign c_den[0]   = f_den;
  assign c_d[0]     = '0;

  for (genvar k = 0; k < DB; k++) begin : g_cell
    psd_cell #(.NW(NW), .DNW(DNW), .DB(DB), .BIT(DB - 1 - k)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .i_valid (c_valid[k]),
      .i_rem   (c_rem[k]),
      .i_q     (c_q[k]),
      .i_den   (c_den[k]),
      .i_d     (c_d[k]),
      .o_valid (c_valid[k+1]),
      .o_rem   (c_rem[k+1]),
      .o_q     (c_q[k+1]),
      .o_den   (c_den[k+1]),
      .o_d     (c_d[k+1])
    );
  end

  // exact distance <= threshold: floor below it, or equal with zero remainder
  logic [CW-1:0] d_ext, thr_ext;
  logic          within_next;
  logic [DIST_BITS-1:0] dist_next;

  always_comb begin
    d_ext       = CW'(c_d[DB]);
    thr_ext     = CW'(threshold);
    within_next = (d_ext < thr_ext) || ((d_ext == thr_ext) && (c_rem[DB] == '0));
    dist_next   = (d_ext > CW'(DIST_MAX)) ? DIST_MAX : d_ext[DIST_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= c_valid[DB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      distance   <= dist_next;
      within_res <= within_next;
    end
  end
endmodule

// ===== hdl/psd_front.sv =====
// ----------------------------------------------------------------------------
// psd_front
// differences, products, case select and squared numerator / denominator
// ----------------------------------------------------------------------------
module psd_front import psd_pkg::*; #(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_ok,
  input  logic signed [COORD_BITS-1:0] px,
  input  logic signed [COORD_BITS-1:0] py,
  input  logic signed [COORD_BITS-1:0] hx,
  input  logic signed [COORD_BITS-1:0] hy,
  input  logic signed [COORD_BITS-1:0] tx,
  input  logic signed [COORD_BITS-1:0] ty,
  output logic                         f_valid,
  output logic [4*(COORD_BITS+1)-1:0]  f_num,
  output logic [2*(COORD_BITS+1)-1:0]  f_den
);
  localparam int W  = COORD_BITS + 1;
  localparam int PW = 2 * W;
  localparam int SW = PW + 1;
  localparam int NW = 4 * W;

  logic [4:0] vld;

  // stage 1
  logic signed [W-1:0] vx, vy, wx, wy, ex, ey;
  // stage 2
  logic signed [PW-1:0] p_vxex, p_vyey, p_wxex, p_wyey, p_exvy, p_eyvx;
  logic signed [PW-1:0] p_vxvx, p_vyvy, p_wxwx, p_wywy, p_exex, p_eyey;
  // stage 3
  logic signed [SW-1:0] dot1, dot2n, cr, s1, s2, dn;
  logic [PW-1:0] cr_abs, ep_sel;
  logic [PW-1:0] cr_mag, ep_min, den3;
  logic          inner3;
  // stage 4
  logic [PW-1:0] hh, hl, ll, ep4, den4;
  logic          inner4;
  // stage 5
  logic [NW-1:0] cr_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], in_ok};
    end
  end

  always_comb begin
    dot1   = SW'(p_vxex) + SW'(p_vyey);
    dot2n  = SW'(p_wxex) + SW'(p_wyey);
    cr     = SW'(p_exvy) - SW'(p_eyvx);
    s1     = SW'(p_vxvx) + SW'(p_vyvy);
    s2     = SW'(p_wxwx) + SW'(p_wywy);
    dn     = SW'(p_exex) + SW'(p_eyey);
    cr_abs = cr[SW-1] ? PW'(-cr) : PW'(cr);
    ep_sel = (s1 < s2) ? PW'(s1) : PW'(s2);
    cr_sq  = {hh, {PW{1'b0}}} + (NW'(hl) << (W + 1)) + NW'(ll);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vx <= W'(px) - W'(hx);
      vy <= W'(py) - W'(hy);
      wx <= W'(px) - W'(tx);
      wy <= W'(py) - W'(ty);
      ex <= W'(tx) - W'(hx);
      ey <= W'(ty) - W'(hy);

      p_vxex <= vx * ex;
      p_vyey <= vy * ey;
      p_wxex <= wx * ex;
      p_wyey <= wy * ey;
      p_exvy <= ex * vy;
      p_eyvx <= ey * vx;
      p_vxvx <= vx * vx;
      p_vyvy <= vy * vy;
      p_wxwx <= wx * wx;
      p_wywy <= wy * wy;
      p_exex <= ex * ex;
      p_eyey <= ey * ey;

      // foot of perpendicular strictly inside the segment
      inner3 <= !dot1[SW-1] && (dot1 != '0) && dot2n[SW-1];
      cr_mag <= cr_abs;
      ep_min <= ep_sel;
      den3   <= PW'(dn);

      hh     <= PW'(cr_mag[PW-1:W]) * PW'(cr_mag[PW-1:W]);
      hl     <= PW'(cr_mag[PW-1:W]) * PW'(cr_mag[W-1:0]);
      ll     <= PW'(cr_mag[W-1:0]) * PW'(cr_mag[W-1:0]);
      inner4 <= inner3;
      ep4    <= ep_min;
      den4   <= den3;

      f_num  <= inner4 ? cr_sq : NW'(ep4);
      f_den  <= inner4 ? den4 : PW'(1);
    end
  end

  assign f_valid = vld[4];
endmodule

// ===== hdl/psd_cell.sv =====
// ----------------------------------------------------------------------------
// psd_cell
// one result bit of the square root of num / den
// ----------------------------------------------------------------------------
module psd_cell import psd_pkg::*; #(
  parameter int NW  = 100,
  parameter int DNW = 50,
  parameter int DB  = 26,
  parameter int BIT = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                i_valid,
  input  logic [NW-1:0]       i_rem,
  input  logic [DB+DNW-1:0]   i_q,
  input  logic [DNW-1:0]      i_den,
  input  logic [DB-1:0]       i_d,
  output logic                o_valid,
  output logic [NW-1:0]       o_rem,
  output logic [DB+DNW-1:0]   o_q,
  output logic [DNW-1:0]      o_den,
  output logic [DB-1:0]       o_d
);
  localparam int XW = NW + 4;
  localparam int QW = DB + DNW;

  logic [XW-1:0] trial;
  logic          take;

  // (d + 2^b)^2 den - d^2 den = 2^(b+1) d den + 2^(2b) den
  always_comb begin
    trial = (XW'(i_q) << (BIT + 1)) + (XW'(i_den) << (2 * BIT));
    take  = XW'(i_rem) >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (en) begin
      o_valid <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_rem <= take ? (i_rem - trial[NW-1:0]) : i_rem;
      o_q   <= take ? (i_q + (QW'(i_den) << BIT)) : i_q;
      o_den <= i_den;
      o_d   <= take ? (i_d | (DB'(1) << BIT)) : i_d;
    end
  end
endmodule

// ===== verif/point_segment_distance_checker.sv =====
// ----------------------------------------------------------------------------
// point_segment_distance_checker
// predicts distance and threshold flag per input transaction and compares
// each output transaction against the oldest prediction
// ----------------------------------------------------------------------------
module point_segment_distance_checker import psd_pkg::*; #(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [THR_BITS-1:0]          cfg_wdata,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic signed [COORD_BITS-1:0] head_x,
  input  logic signed [COORD_BITS-1:0] head_y,
  input  logic signed [COORD_BITS-1:0] tail_x,
  input  logic signed [COORD_BITS-1:0] tail_y,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [DIST_BITS-1:0]         distance,
  input  logic                         within_res,
  output int                           errors,
  output int                           pending
);

  typedef struct packed {
    logic [DIST_BITS-1:0] dist_val;
    logic                 near_flag;
  } answer_t;

  logic [THR_BITS-1:0] thr_copy;
  answer_t             answer_queue[$];

  // exact squared distance as ratio num/den, then bitwise floor root
  function automatic answer_t predict_distance(
    input logic signed [COORD_BITS-1:0] px, py, hx, hy, tx, ty,
    input logic [THR_BITS-1:0] thr
  );
    longint       vx, vy, wx, wy, ex, ey, dot_h, dot_t, cr, s1, s2;
    logic [127:0] num, den, cand, lim;
    logic [63:0]  root;
    answer_t      ans;
    vx = longint'(px) - longint'(hx);
    vy = longint'(py) - longint'(hy);
    wx = longint'(px) - longint'(tx);
    wy = longint'(py) - longint'(ty);
    ex = longint'(tx) - longint'(hx);
    ey = longint'(ty) - longint'(hy);
    dot_h = vx * ex + vy * ey;
    dot_t = -(wx * ex) - (wy * ey);
    if (dot_h > 0 && dot_t > 0) begin
      // foot of the perpendicular strictly inside the segment
      cr = ex * vy - ey * vx;
      if (cr < 0) cr = -cr;
      num = 128'(cr) * 128'(cr);
      den = 128'(ex * ex + ey * ey);
    end else begin
      s1 = vx * vx + vy * vy;
      s2 = wx * wx + wy * wy;
      num = 128'(s1 < s2 ? s1 : s2);
      den = 128'd1;
    end
    root = '0;
    for (int b = COORD_BITS + 1; b >= 0; b--) begin
      cand = 128'(root | (64'd1 << b));
      if (cand * cand * den <= num) root = cand[63:0];
    end
    ans.dist_val = (root > 64'(DIST_MAX)) ? DIST_MAX : root[DIST_BITS-1:0];
    lim = 128'(thr) * 128'(thr) * den;
    ans.near_flag = (num <= lim);
    return ans;
  endfunction

  assign pending = answer_queue.size();

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      thr_copy <= '0;
      errors   <= 0;
      answer_queue.delete();
    end else begin
      if (in_valid && !in_stall)
        answer_queue.insert(answer_queue.size(),
                            predict_distance(point_x, point_y, head_x, head_y,
                                             tail_x, tail_y, thr_copy));
      if (out_valid && !out_stall) begin
        if (answer_queue.size() == 0) begin
          $display("%0t: unexpected result distance=%0d within=%0b",
                   $time, distance, within_res);
          errors <= errors + 1;
        end else begin
          want = answer_queue.pop_front();
          if (distance !== want.dist_val || within_res !== want.near_flag) begin
            $display("%0t: mismatch distance exp=%0d act=%0d within exp=%0b act=%0b",
                     $time, want.dist_val, distance, want.near_flag, within_res);
            errors <= errors + 1;
          end
        end
      end
      if (cfg_we) thr_copy <= cfg_wdata;
    end
  end

endmodule

// ===== verif/point_segment_distance_tb.sv =====
// ----------------------------------------------------------------------------
// point_segment_distance_tb
// directed geometry cases and randomized points and segments under random
// input gaps and output stalls, over several threshold settings
// ----------------------------------------------------------------------------
module point_segment_distance_tb;
  import psd_pkg::*;

  localparam int COORD_BITS = 24;
  localparam int LATENCY    = COORD_BITS + 8;
  localparam int IDLE_LIMIT = 3000;   // longest stall or gap plus the pipe, many times over
  localparam int PHASE_ITEMS = 170;

  localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_we = 1'b0;
  logic [THR_BITS-1:0]          cfg_wdata = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic signed [COORD_BITS-1:0] point_x = '0, point_y = '0;
  logic signed [COORD_BITS-1:0] head_x = '0, head_y = '0;
  logic signed [COORD_BITS-1:0] tail_x = '0, tail_y = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [DIST_BITS-1:0]         distance;
  logic                         within_res;
  int                           errors, pending;

  // when set, neither side idles (back to back stretches)
  logic calm = 1'b0;
  int   idle_cycles = 0;
  int   stall_left = 0;

  always #5 clk = ~clk;

  point_segment_distance #(.COORD_BITS(COORD_BITS)) dut (
    .clk, .rst, .cfg_we, .cfg_wdata, .in_valid, .in_stall,
    .point_x, .point_y, .head_x, .head_y, .tail_x, .tail_y,
    .out_valid, .out_stall, .distance, .within_res
  );

  point_segment_distance_checker #(.COORD_BITS(COORD_BITS)) checker_i (
    .clk, .rst, .cfg_we, .cfg_wdata, .in_valid, .in_stall,
    .point_x, .point_y, .head_x, .head_y, .tail_x, .tail_y,
    .out_valid, .out_stall, .distance, .within_res, .errors, .pending
  );

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  // output side back pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      stall_left <= gap_len();
      out_stall  <= 1'b0;
    end
  end

  // watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("point_segment_distance_tb: done, errors");
      $finish;
    end
  end

  // one input transaction, valid stays high into the next one when no gap
  task automatic send_query(input logic signed [COORD_BITS-1:0] px, py, hx, hy, tx, ty);
    int gap;
    gap = calm ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    point_x <= px; point_y <= py;
    head_x  <= hx; head_y  <= hy;
    tail_x  <= tx; tail_y  <= ty;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // threshold write only with the pipe drained
  task automatic set_threshold(input logic [THR_BITS-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // hand picked geometry: extremes, degenerate, interior, endpoint, foot on an end
  task automatic directed_set();
    send_query('0, '0, '0, '0, '0, '0);
    send_query(CMAX, CMAX, CMIN, CMIN, CMIN, CMIN);     // degenerate, farthest point
    send_query(CMIN, CMIN, CMAX, CMAX, CMAX, CMAX);
    send_query(CMIN, CMAX, CMAX, CMIN, CMAX, CMAX);
    send_query(CMIN, CMAX, CMIN, CMIN, CMAX, CMAX);     // longest segment, interior
    send_query(CMAX, CMIN, CMIN, CMIN, CMAX, CMAX);
    send_query(24'sd0, 24'sd5, -24'sd10, 24'sd0, 24'sd10, 24'sd0);   // interior, exact 5
    send_query(24'sd0, 24'sd6, -24'sd10, 24'sd0, 24'sd10, 24'sd0);
    send_query(24'sd0, 24'sd0, -24'sd10, 24'sd0, 24'sd10, 24'sd0);   // on the segment
    send_query(24'sd13, 24'sd4, -24'sd10, 24'sd0, 24'sd10, 24'sd0);  // past the tail
    send_query(-24'sd13, 24'sd4, -24'sd10, 24'sd0, 24'sd10, 24'sd0); // before the head
    send_query(-24'sd10, 24'sd7, -24'sd10, 24'sd0, 24'sd10, 24'sd0); // foot on the head
    send_query(24'sd10, -24'sd7, -24'sd10, 24'sd0, 24'sd10, 24'sd0); // foot on the tail
    send_query(24'sd3, 24'sd4, 24'sd0, 24'sd0, 24'sd0, 24'sd0);      // degenerate, exact 5
    send_query(24'sd1, 24'sd1, 24'sd0, 24'sd0, 24'sd2, 24'sd2);      // collinear diagonal
    send_query(24'sd0, 24'sd2, 24'sd0, 24'sd0, 24'sd2, 24'sd2);      // non integer distance
    send_query(-24'sd1, -24'sd1, CMIN, CMAX, CMAX, CMIN);
  endtask

  function automatic logic signed [COORD_BITS-1:0] edge_coord();
    case ($urandom_range(0, 4))
      0: return CMAX;
      1: return CMIN;
      2: return '0;
      3: return COORD_BITS'(-1);
      default: return COORD_BITS'(1);
    endcase
  endfunction

  task automatic random_query();
    logic signed [COORD_BITS-1:0] c[6];
    int mode, base_x, base_y, span;
    mode = $urandom_range(0, 9);
    if (mode < 4) begin
      foreach (c[i]) c[i] = COORD_BITS'($urandom());
    end else if (mode < 8) begin
      // local cluster, so distances land near small thresholds too
      base_x = $signed($urandom_range(0, 8000000)) - 4000000;
      base_y = $signed($urandom_range(0, 8000000)) - 4000000;
      case ($urandom_range(0, 2))
        0: span = 15;
        1: span = 1000;
        default: span = 65535;
      endcase
      foreach (c[i])
        c[i] = COORD_BITS'(((i % 2) ? base_y : base_x)
                           + $signed($urandom_range(0, 2 * span)) - span);
    end else if (mode == 8) begin
      foreach (c[i]) c[i] = COORD_BITS'($urandom());
      c[4] = c[2];
      c[5] = c[3];
    end else begin
      foreach (c[i]) c[i] = edge_coord();
    end
    send_query(c[0], c[1], c[2], c[3], c[4], c[5]);
  endtask

  initial begin
    logic [THR_BITS-1:0] phase_thr[5];
    phase_thr[0] = DIST_MAX;
    phase_thr[1] = THR_BITS'($urandom_range(0, 2000));
    phase_thr[2] = THR_BITS'($urandom());
    phase_thr[3] = '0;
    phase_thr[4] = 25'd70000;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // threshold zero from reset, then exact-five boundary
    directed_set();
    set_threshold(25'd5);
    directed_set();

    for (int ph = 0; ph < 5; ph++) begin
      set_threshold(phase_thr[ph]);
      calm <= (ph == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) random_query();
    end
    in_valid <= 1'b0;
    calm     <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("point_segment_distance_tb: done, clean");
    else
      $display("point_segment_distance_tb: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/psd_pkg.sv
hdl/psd_front.sv
hdl/psd_cell.sv
hdl/point_segment_distance.sv
verif/point_segment_distance_checker.sv
verif/point_segment_distance_tb.sv
